// ----- rtl/mpfb_pkg.sv -----
package mpfb_pkg;

	localparam logic [2:0] KIND_PIXEL = 3'd0;
	localparam logic [2:0] KIND_ROW   = 3'd1;
	localparam logic [2:0] KIND_COL   = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	localparam int ADDR_WIDE_W = 14;
	localparam int CMDQ_DEPTH  = 2;
	localparam int RESQ_DEPTH  = 2;
	localparam int RESQ_CW     = $clog2(RESQ_DEPTH + 1);

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] bits;
		logic [9:0] read_index;
	} mpfb_cmd_t;

	localparam int CMD_W = $bits(mpfb_cmd_t);

endpackage

// ----- rtl/mpfb_queue.sv -----
module mpfb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               din,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               dout,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on pop");
`endif

endmodule

// ----- rtl/mpfb_front.sv -----
module mpfb_front (
	input  logic               push,
	input  logic               full,
	input  logic [2:0]         kind,
	input  logic [7:0]         x,
	input  logic [7:0]         y,
	input  logic               value,
	input  logic [7:0]         bits,
	input  logic [9:0]         read_index,
	output logic               cmd_push,
	output mpfb_pkg::mpfb_cmd_t cmd
);

	logic known;

	always_comb begin
		unique case (kind)
			mpfb_pkg::KIND_PIXEL,
			mpfb_pkg::KIND_ROW,
			mpfb_pkg::KIND_COL,
			mpfb_pkg::KIND_CLEAR,
			mpfb_pkg::KIND_READ: known = 1'b1;
			default:             known = 1'b0;
		endcase
	end

	// drop unused kinds here; a single pixel travels as a one-step column
	assign cmd_push = push && !full && known;

	always_comb begin
		cmd.kind       = kind;
		cmd.x          = x;
		cmd.y          = y;
		cmd.bits       = (kind == mpfb_pkg::KIND_PIXEL) ? {7'd0, value} : bits;
		cmd.read_index = read_index;
	end

endmodule

// ----- rtl/mpfb_back.sv -----
module mpfb_back #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_empty,
	input  mpfb_pkg::mpfb_cmd_t           cmd,
	output logic                          cmd_pop,
	input  logic [mpfb_pkg::RESQ_CW-1:0]  res_count,
	output logic                          res_push,
	output logic [7:0]                    res_data,
	output logic                          clearing
);

	localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE = PANEL_WIDTH * PAGES;
	localparam int AW    = $clog2(STORE);
	localparam int XW    = mpfb_pkg::ADDR_WIDE_W;
	localparam int RCW   = mpfb_pkg::RESQ_CW + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(STORE - 1);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DRAW  = 3'd2;
	localparam logic [2:0] ST_CLEAR = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;

	logic [7:0] mem [STORE];

	logic [2:0]          st_q;
	mpfb_pkg::mpfb_cmd_t cmd_q;
	logic [2:0]          step_q;
	logic [AW-1:0]       clr_addr_q;

	logic          room;
	logic          last_step;
	logic          issue_draw;
	logic          issue_read;
	logic [7:0]    col;
	logic [7:0]    row;
	logic          pix_val;
	logic          on_panel;
	logic [XW-1:0] draw_wide;
	logic [AW-1:0] raddr;
	logic          rd_in_range;

	logic          v_s2;
	logic          rd_s2;
	logic [AW-1:0] addr_s2;
	logic [2:0]    bit_s2;
	logic          val_s2;
	logic          zero_s2;
	logic          fwd_s2;
	logic [7:0]    fwd_data_s2;
	logic [7:0]    rdata_s2;

	logic [7:0]    base;
	logic [7:0]    mask;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	assign clearing = (st_q == ST_INIT);
	assign cmd_pop  = (st_q == ST_IDLE) && !cmd_empty;
	assign room     = (RCW'(res_count) + RCW'(rd_s2)) < RCW'(mpfb_pkg::RESQ_DEPTH);
	assign last_step = ((cmd_q.kind != mpfb_pkg::KIND_ROW) &&
		(cmd_q.kind != mpfb_pkg::KIND_COL)) || (step_q == 3'd7);
	assign issue_draw = (st_q == ST_DRAW);
	assign issue_read = (st_q == ST_READ) && room;

	always_comb begin
		if (cmd_q.kind == mpfb_pkg::KIND_ROW) begin
			col     = cmd_q.x + 8'(step_q);
			row     = cmd_q.y;
			pix_val = cmd_q.bits[3'd7 - step_q];
		end else begin
			col     = cmd_q.x;
			row     = cmd_q.y + 8'(step_q);
			pix_val = cmd_q.bits[step_q];
		end
		on_panel    = ({1'b0, col} < 9'(PANEL_WIDTH)) && ({1'b0, row} < 9'(PANEL_HEIGHT));
		draw_wide   = XW'(row[7:3]) * XW'(PANEL_WIDTH) + XW'(col);
		rd_in_range = XW'(cmd_q.read_index) < XW'(STORE);
		raddr       = issue_read ? AW'(cmd_q.read_index) : draw_wide[AW-1:0];
	end

	always_comb begin
		base  = fwd_s2 ? fwd_data_s2 : rdata_s2;
		mask  = 8'h01 << bit_s2;
		we    = v_s2 || (st_q == ST_INIT) || (st_q == ST_CLEAR);
		waddr = v_s2 ? addr_s2 : clr_addr_q;
		if (!v_s2) begin
			wdata = 8'd0;
		end else if (val_s2) begin
			wdata = base | mask;
		end else begin
			wdata = base & ~mask;
		end
	end

	assign res_push = rd_s2;
	assign res_data = zero_s2 ? 8'd0 : base;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s2 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		addr_s2     <= raddr;
		bit_s2      <= row[2:0];
		val_s2      <= pix_val;
		zero_s2     <= !rd_in_range;
		fwd_s2      <= we && (waddr == raddr);
		fwd_data_s2 <= wdata;
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_INIT;
			step_q     <= '0;
			clr_addr_q <= '0;
			v_s2       <= 1'b0;
			rd_s2      <= 1'b0;
		end else begin
			v_s2  <= issue_draw && on_panel;
			rd_s2 <= issue_read;
			unique case (st_q)
				ST_INIT, ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					step_q     <= '0;
					clr_addr_q <= '0;
					if (cmd_pop) begin
						priority if (cmd.kind == mpfb_pkg::KIND_CLEAR) begin
							st_q <= ST_CLEAR;
						end else if (cmd.kind == mpfb_pkg::KIND_READ) begin
							st_q <= ST_READ;
						end else begin
							st_q <= ST_DRAW;
						end
					end
				end
				ST_DRAW: begin
					step_q <= step_q + 1'b1;
					if (last_step) begin
						st_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (room) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !((st_q == ST_CLEAR) || (st_q == ST_INIT)))
		else $error("pixel write collides with clearing sweep");
	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s2 |-> res_count < mpfb_pkg::RESQ_CW'(mpfb_pkg::RESQ_DEPTH))
		else $error("read result with no room in result queue");
	a_stage_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s2 && rd_s2))
		else $error("write and read beat share the second stage");
	a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(clearing || (st_q == ST_CLEAR)) |-> !cmd_pop)
		else $error("command taken during clearing sweep");
`endif

endmodule

// ----- rtl/mono_page_framebuffer_drawer.sv -----
// channel | direction | handshake         | fields
// item    | in        | push / full       | kind, x, y, value, bits, read_index
// result  | out       | pop / empty       | read_data
//
// Set pixel and row and column draws do one read-modify-write per pixel
// through the frame store's single write port.
// Clear-all zeroes all PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) bytes, one byte a cycle.
// After reset the same sweep runs with full high.
// A two-entry command queue and a two-entry result queue let each side stall on its own.
module mono_page_framebuffer_drawer #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] kind,
	input  logic [7:0] x,
	input  logic [7:0] y,
	input  logic       value,
	input  logic [7:0] bits,
	input  logic [9:0] read_index,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] read_data
);

	mpfb_pkg::mpfb_cmd_t              fe_cmd;
	mpfb_pkg::mpfb_cmd_t              be_cmd;
	logic                             fe_push;
	logic                             cmdq_full;
	logic                             cmdq_empty;
	logic                             be_pop;
	logic [mpfb_pkg::CMD_W-1:0]       cmdq_dout;
	logic [mpfb_pkg::RESQ_CW-1:0]     res_count;
	logic                             res_push;
	logic [7:0]                       res_data;
	logic                             clearing;

	assign full   = cmdq_full || clearing;
	assign be_cmd = mpfb_pkg::mpfb_cmd_t'(cmdq_dout);

	mpfb_front u_front (
		.push       (push),
		.full       (full),
		.kind       (kind),
		.x          (x),
		.y          (y),
		.value      (value),
		.bits       (bits),
		.read_index (read_index),
		.cmd_push   (fe_push),
		.cmd        (fe_cmd)
	);

	mpfb_queue #(
		.WIDTH (mpfb_pkg::CMD_W),
		.DEPTH (mpfb_pkg::CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.din    (fe_cmd),
		.full   (cmdq_full),
		.pop    (be_pop),
		.dout   (cmdq_dout),
		.empty  (cmdq_empty),
		.count  ()
	);

	mpfb_back #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmdq_empty),
		.cmd       (be_cmd),
		.cmd_pop   (be_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res_data  (res_data),
		.clearing  (clearing)
	);

	mpfb_queue #(
		.WIDTH (8),
		.DEPTH (mpfb_pkg::RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_data),
		.full   (),
		.pop    (pop),
		.dout   (read_data),
		.empty  (empty),
		.count  (res_count)
	);

endmodule
